// ===== sv/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants for the text position tracker: the position
// record, command and status codes, character codes and default depth.
// ----------------------------------------------------------------------------
package tpt_pkg;

   localparam int POS_W             = 24;
   localparam int CHAR_W            = 21;
   localparam int STACK_DEPTH_DFLT  = 64;

   localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
   localparam logic [CHAR_W-1:0] CODE_CR  = CHAR_W'(13);
   localparam logic [CHAR_W-1:0] CODE_LF  = CHAR_W'(10);

   typedef enum logic [2:0] {
      CMD_FORWARD = 3'd0,
      CMD_SAVE    = 3'd1,
      CMD_LOAD    = 3'd2,
      CMD_DROP    = 3'd3,
      CMD_ERASE   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_AT_END    = 2'd1,
      ST_FULL      = 2'd2,
      ST_TOO_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0] offset;
      logic [POS_W-1:0] line;
      logic [POS_W-1:0] column;
   } position_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

endpackage

// ===== sv/tpt_stack.sv =====
// ----------------------------------------------------------------------------
// tpt_stack
// Checkpoint stack: full contents in a memory, the two top entries cached in
// registers, and the entry below them prefetched every cycle so that pops
// can follow each other in consecutive cycles.
// ----------------------------------------------------------------------------
module tpt_stack
   import tpt_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DFLT,
   localparam int FW = $clog2(STACK_DEPTH + 1),
   localparam int AW = $clog2(STACK_DEPTH)
) (
   input  logic         clock,
   input  logic         reset,
   input  stack_op_type op,
   input  position_type push_data,
   output logic [FW-1:0] fill,
   output logic [FW-1:0] fill_next,
   output position_type top,
   output position_type second
);

   position_type  mem [STACK_DEPTH];
   position_type  below_ff;
   position_type  top_ff;
   position_type  top_in;
   position_type  second_ff;
   position_type  second_in;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [FW-1:0] below_idx;

   always_comb begin
      fill_in   = fill_ff;
      top_in    = top_ff;
      second_in = second_ff;
      priority if (op.push) begin
         fill_in   = fill_ff + FW'(1);
         top_in    = push_data;
         second_in = top_ff;
      end else if (op.pop) begin
         fill_in   = fill_ff - FW'(1);
         top_in    = second_ff;
         second_in = below_ff;
      end
   end

   // third entry from the top for the next fill level
   assign below_idx = fill_in - FW'(3);

   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[fill_ff[AW-1:0]] <= push_data;
      end
      below_ff <= mem[below_idx[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      second_ff <= second_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign fill      = fill_ff;
   assign fill_next = fill_in;
   assign top       = top_ff;
   assign second    = second_ff;

endmodule

// ===== sv/text_position_tracker_with_checkpoints.sv =====
// ----------------------------------------------------------------------------
// text_position_tracker_with_checkpoints
// A request passes through the input register and then the result register.
// Throughput: one transaction per cycle while the response side is not stalled;
// the position and stack state update in the single stage after the input register.
// Reset (synchronous): offset 0, line 1, column 1, empty stack, length 0.
// The checkpoint memory needs no clearing pass.
// ----------------------------------------------------------------------------
module text_position_tracker_with_checkpoints
   import tpt_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DFLT,
   localparam int FW = $clog2(STACK_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_command,
   input  logic [CHAR_W-1:0] req_current_char,
   input  logic [CHAR_W-1:0] req_following_char,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_read_offset,
   output logic [POS_W-1:0]  rsp_line,
   output logic [POS_W-1:0]  rsp_column,
   output logic              rsp_at_end,
   output logic              rsp_at_start,
   output logic [FW-1:0]     rsp_checkpoint_count,
   output logic [1:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [POS_W-1:0]  csr_source_length
);

   logic [POS_W-1:0]  length_ff;
   logic              s1_valid_ff;
   command_type       s1_cmd_ff;
   logic [CHAR_W-1:0] s1_cur_ff;
   logic [CHAR_W-1:0] s1_next_ff;
   position_type      pos_ff;
   position_type      pos_in;
   logic              rsp_valid_ff;
   position_type      rsp_pos_ff;
   logic              rsp_at_end_ff;
   logic              rsp_at_start_ff;
   logic [FW-1:0]     rsp_count_ff;
   status_type        rsp_status_ff;

   logic              advance;
   logic              req_accept;
   status_type        status_d;
   logic              push_d;
   logic              pop_d;
   stack_op_type      stack_op;
   logic [FW-1:0]     fill;
   logic [FW-1:0]     fill_next;
   position_type      stack_top;
   position_type      stack_second;
   logic [POS_W-1:0]  offset_inc;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_valid) begin
         length_ff <= csr_source_length;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= command_type'(req_command);
         s1_cur_ff  <= req_current_char;
         s1_next_ff <= req_following_char;
      end
   end

   assign offset_inc = pos_ff.offset + POS_W'(1);

   always_comb begin
      pos_in   = pos_ff;
      status_d = ST_OK;
      push_d   = 1'b0;
      pop_d    = 1'b0;
      unique case (s1_cmd_ff)
         CMD_FORWARD: begin
            if (pos_ff.offset >= length_ff) begin
               status_d = ST_AT_END;
            end else if (s1_cur_ff == CODE_CR || s1_cur_ff == CODE_LF) begin
               pos_in.line   = (pos_ff.line == POS_MAX) ? POS_MAX
                                                        : pos_ff.line + POS_W'(1);
               pos_in.column = POS_W'(1);
               // cr lf pair moves past both unless the lf is beyond the end
               if (s1_cur_ff == CODE_CR && offset_inc != length_ff
                   && s1_next_ff == CODE_LF) begin
                  pos_in.offset = pos_ff.offset + POS_W'(2);
               end else begin
                  pos_in.offset = offset_inc;
               end
            end else begin
               pos_in.offset = offset_inc;
               pos_in.column = (pos_ff.column == POS_MAX) ? POS_MAX
                                                          : pos_ff.column + POS_W'(1);
            end
         end
         CMD_SAVE: begin
            if (fill == FW'(STACK_DEPTH)) begin
               status_d = ST_FULL;
            end else begin
               push_d = 1'b1;
            end
         end
         CMD_LOAD: begin
            if (fill == '0) begin
               status_d = ST_TOO_EMPTY;
            end else begin
               pop_d  = 1'b1;
               pos_in = stack_top;
            end
         end
         CMD_DROP: begin
            if (fill < FW'(2)) begin
               status_d = ST_TOO_EMPTY;
            end else begin
               pop_d  = 1'b1;
               pos_in = stack_second;
            end
         end
         CMD_ERASE: begin
            if (fill == '0) begin
               status_d = ST_TOO_EMPTY;
            end else begin
               pop_d = 1'b1;
            end
         end
         default: begin
            status_d = ST_OK;
         end
      endcase
   end

   assign stack_op.push = advance && push_d;
   assign stack_op.pop  = advance && pop_d;

   tpt_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .op        (stack_op),
      .push_data (pos_ff),
      .fill      (fill),
      .fill_next (fill_next),
      .top       (stack_top),
      .second    (stack_second)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff.offset <= '0;
         pos_ff.line   <= POS_W'(1);
         pos_ff.column <= POS_W'(1);
      end else if (advance) begin
         pos_ff <= pos_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pos_ff      <= pos_in;
         rsp_at_end_ff   <= pos_in.offset >= length_ff;
         rsp_at_start_ff <= pos_in.offset == '0;
         rsp_count_ff    <= fill_next;
         rsp_status_ff   <= status_d;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_offset      = rsp_pos_ff.offset;
   assign rsp_line             = rsp_pos_ff.line;
   assign rsp_column           = rsp_pos_ff.column;
   assign rsp_at_end           = rsp_at_end_ff;
   assign rsp_at_start         = rsp_at_start_ff;
   assign rsp_checkpoint_count = rsp_count_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

// ===== sim/tpt_position_checker.sv =====
// ----------------------------------------------------------------------------
// tpt_position_checker
// Watches the request, response and length-write channels of the text
// position tracker. Keeps its own copy of the read position, the checkpoint
// stack and the source length, works out the expected response for every
// accepted request and compares each accepted response, field by field,
// against the oldest expectation. Reports the mismatch count and the number
// of responses still owed.
// ----------------------------------------------------------------------------
module tpt_position_checker
   import tpt_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DFLT,
   localparam int FW = $clog2(STACK_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [2:0]        req_command,
   input  logic [CHAR_W-1:0] req_current_char,
   input  logic [CHAR_W-1:0] req_following_char,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [POS_W-1:0]  rsp_read_offset,
   input  logic [POS_W-1:0]  rsp_line,
   input  logic [POS_W-1:0]  rsp_column,
   input  logic              rsp_at_end,
   input  logic              rsp_at_start,
   input  logic [FW-1:0]     rsp_checkpoint_count,
   input  logic [1:0]        rsp_status,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [POS_W-1:0]  csr_source_length,
   output int                error_count,
   output int                pending_count
);

   localparam int AW = $clog2(STACK_DEPTH);

   typedef struct {
      position_type  pos;
      logic          at_end;
      logic          at_start;
      logic [FW-1:0] count;
      status_type    status;
   } tracker_view_type;

   position_type     cur_pos;
   position_type     checkpoints [STACK_DEPTH];
   int unsigned      fill;
   logic [POS_W-1:0] length_cfg;
   tracker_view_type expected_views [$];
   tracker_view_type oldest;

   function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   task automatic track_command(input logic [2:0]        cmd,
                                input logic [CHAR_W-1:0] ch,
                                input logic [CHAR_W-1:0] next_ch);
      status_type       st;
      tracker_view_type view;
      st = ST_OK;
      case (cmd)
         CMD_FORWARD: begin
            if (cur_pos.offset >= length_cfg) begin
               st = ST_AT_END;
            end else if (ch == CODE_CR || ch == CODE_LF) begin
               cur_pos.line   = bump(cur_pos.line);
               cur_pos.column = POS_W'(1);
               cur_pos.offset = cur_pos.offset + 1'b1;
               // cr lf pair is one line break unless the cr was the last character
               if (ch == CODE_CR && cur_pos.offset != length_cfg && next_ch == CODE_LF) begin
                  cur_pos.offset = cur_pos.offset + 1'b1;
               end
            end else begin
               cur_pos.offset = cur_pos.offset + 1'b1;
               cur_pos.column = bump(cur_pos.column);
            end
         end
         CMD_SAVE: begin
            if (fill >= STACK_DEPTH) begin
               st = ST_FULL;
            end else begin
               checkpoints[AW'(fill)] = cur_pos;
               fill++;
            end
         end
         CMD_LOAD: begin
            if (fill == 0) begin
               st = ST_TOO_EMPTY;
            end else begin
               fill--;
               cur_pos = checkpoints[AW'(fill)];
            end
         end
         CMD_DROP: begin
            if (fill < 2) begin
               st = ST_TOO_EMPTY;
            end else begin
               fill--;
               cur_pos = checkpoints[AW'(fill - 1)];
            end
         end
         CMD_ERASE: begin
            if (fill == 0) begin
               st = ST_TOO_EMPTY;
            end else begin
               fill--;
            end
         end
         default: begin
         end
      endcase
      view.pos      = cur_pos;
      view.at_end   = (cur_pos.offset >= length_cfg);
      view.at_start = (cur_pos.offset == '0);
      view.count    = FW'(fill);
      view.status   = st;
      expected_views.push_back(view);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_pos.offset = '0;
         cur_pos.line   = POS_W'(1);
         cur_pos.column = POS_W'(1);
         fill           = 0;
         length_cfg     = '0;
         error_count    = 0;
         expected_views.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            length_cfg = csr_source_length;
         end
         if (req_valid && req_ready) begin
            track_command(req_command, req_current_char, req_following_char);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               oldest = expected_views.pop_front();
               check_field("read_offset", 32'(oldest.pos.offset), 32'(rsp_read_offset));
               check_field("line", 32'(oldest.pos.line), 32'(rsp_line));
               check_field("column", 32'(oldest.pos.column), 32'(rsp_column));
               check_field("at_end", 32'(oldest.at_end), 32'(rsp_at_end));
               check_field("at_start", 32'(oldest.at_start), 32'(rsp_at_start));
               check_field("checkpoint_count", 32'(oldest.count),
                           32'(rsp_checkpoint_count));
               check_field("status", 32'(oldest.status), 32'(rsp_status));
            end
         end
      end
      pending_count <= expected_views.size();
   end

endmodule

// ===== sim/tb_text_position_tracker_with_checkpoints.sv =====
// ----------------------------------------------------------------------------
// tb_text_position_tracker_with_checkpoints
// Drives the text position tracker with a short directed run of line breaks,
// end-of-source and stack corner cases, then with lexer-like random traffic
// (checkpoint, scan, backtrack or commit) over several source lengths and
// handshake pacing modes. A separate checker predicts and compares every
// response transaction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_text_position_tracker_with_checkpoints;
   import tpt_pkg::*;

   localparam int STACK_DEPTH    = STACK_DEPTH_DFLT;
   localparam int FW             = $clog2(STACK_DEPTH + 1);
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int CHAR_MAX       = 1114111;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_command = 3'd0;
   logic [CHAR_W-1:0] req_current_char = '0;
   logic [CHAR_W-1:0] req_following_char = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [POS_W-1:0]  rsp_read_offset;
   logic [POS_W-1:0]  rsp_line;
   logic [POS_W-1:0]  rsp_column;
   logic              rsp_at_end;
   logic              rsp_at_start;
   logic [FW-1:0]     rsp_checkpoint_count;
   logic [1:0]        rsp_status;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [POS_W-1:0]  csr_source_length = '0;

   int          error_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          items_issued = 0;
   int unsigned cycle_count = 0;

   text_position_tracker_with_checkpoints #(.STACK_DEPTH(STACK_DEPTH)) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_current_char     (req_current_char),
      .req_following_char   (req_following_char),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_offset      (rsp_read_offset),
      .rsp_line             (rsp_line),
      .rsp_column           (rsp_column),
      .rsp_at_end           (rsp_at_end),
      .rsp_at_start         (rsp_at_start),
      .rsp_checkpoint_count (rsp_checkpoint_count),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_source_length    (csr_source_length)
   );

   tpt_position_checker #(.STACK_DEPTH(STACK_DEPTH)) tracker_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_current_char     (req_current_char),
      .req_following_char   (req_following_char),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_offset      (rsp_read_offset),
      .rsp_line             (rsp_line),
      .rsp_column           (rsp_column),
      .rsp_at_end           (rsp_at_end),
      .rsp_at_start         (rsp_at_start),
      .rsp_checkpoint_count (rsp_checkpoint_count),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_source_length    (csr_source_length),
      .error_count          (error_count),
      .pending_count        (pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_item(input logic [2:0]        cmd,
                            input logic [CHAR_W-1:0] ch,
                            input logic [CHAR_W-1:0] next_ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_current_char   <= ch;
      req_following_char <= next_ch;
      do @(posedge clock); while (!req_ready);
      if (cmd <= CMD_ERASE) begin
         items_issued++;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_length(input logic [POS_W-1:0] len);
      csr_valid         <= 1'b1;
      csr_source_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return CODE_CR;
      end else if (r < 30) begin
         return CODE_LF;
      end else if (r < 40) begin
         return CHAR_W'($urandom_range(0, CHAR_MAX));
      end
      return CHAR_W'($urandom_range(32, 126));
   endfunction

   task automatic forward_char();
      logic [CHAR_W-1:0] ch;
      logic [CHAR_W-1:0] next_ch;
      ch      = pick_char();
      next_ch = ($urandom_range(0, 1) == 1) ? CODE_LF : pick_char();
      send_item(CMD_FORWARD, ch, next_ch);
   endtask

   // lexer-like traffic: checkpoint, scan a token, then backtrack or commit
   task automatic lex_sequence();
      int kind;
      int steps;
      kind = $urandom_range(0, 99);
      if (kind < 64) begin
         send_item(CMD_SAVE, pick_char(), pick_char());
         steps = $urandom_range(0, 6);
         repeat (steps) forward_char();
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            send_item(CMD_LOAD, pick_char(), pick_char());
         end else if (kind < 75) begin
            send_item(CMD_ERASE, pick_char(), pick_char());
         end else if (kind < 90) begin
            send_item(CMD_DROP, pick_char(), pick_char());
         end
      end else if (kind < 80) begin
         steps = $urandom_range(1, 8);
         repeat (steps) forward_char();
      end else if (kind < 88) begin
         steps = $urandom_range(1, 40);
         repeat (steps) send_item(CMD_SAVE, pick_char(), pick_char());
      end else if (kind < 94) begin
         steps = $urandom_range(1, 70);
         repeat (steps) begin
            kind = $urandom_range(0, 2);
            send_item((kind == 0) ? CMD_LOAD : (kind == 1) ? CMD_DROP : CMD_ERASE,
                      pick_char(), pick_char());
         end
      end else begin
         send_item(3'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, CHAR_MAX)),
                   CHAR_W'($urandom_range(0, CHAR_MAX)));
      end
   endtask

   initial begin
      int phase;
      int target;
      logic [POS_W-1:0] len;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty source, empty stack, ignored commands
      send_item(CMD_FORWARD, CHAR_W'(8'h41), CODE_LF);
      send_item(CMD_LOAD, '0, '0);
      send_item(CMD_DROP, '0, '0);
      send_item(CMD_ERASE, '0, '0);
      send_item(3'd5, '0, '0);
      send_item(3'd7, '1, '1);
      settle();

      // six-character source with every kind of line break
      write_length(POS_W'(6));
      send_item(CMD_SAVE, '0, '0);
      send_item(CMD_FORWARD, CHAR_W'(CHAR_MAX), CHAR_W'(20'hFFFFF));
      send_item(CMD_FORWARD, CODE_CR, CODE_LF);
      send_item(CMD_FORWARD, CODE_CR, CHAR_W'(8'h78));
      send_item(CMD_FORWARD, CODE_LF, CODE_CR);
      // cr lf straddling the end of the source
      send_item(CMD_FORWARD, CODE_CR, CODE_LF);
      send_item(CMD_FORWARD, CHAR_W'(20'hFFFFF), CHAR_W'(CHAR_MAX));
      send_item(CMD_SAVE, '0, '0);
      send_item(CMD_DROP, '0, '0);
      send_item(CMD_SAVE, '0, '0);
      send_item(CMD_LOAD, '0, '0);
      send_item(CMD_ERASE, '0, '0);
      send_item(CMD_LOAD, '0, '0);
      send_item(3'd6, CODE_CR, CODE_LF);
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0, 6:    len = POS_MAX;
            1:       len = POS_W'(1);
            3:       len = '0;
            4:       len = POS_W'($urandom_range(40, 400));
            5:       len = POS_W'(12);
            default: len = POS_W'($urandom_range(2, 40));
         endcase
         write_length(len);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 80;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 80;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct     = 13;
            end
         endcase
         target = items_issued + ITEMS_PER_PHASE;
         while (items_issued < target) lex_sequence();
         settle();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
